FILE: design/utr_pkg.sv
// ----------------------------------------------------------------------------
// Resource usage tracker package
// Shared types, codes and sizes for the resource usage tracker.
// ----------------------------------------------------------------------------
package utr_pkg;

    localparam int NUM_RESOURCES = 64;
    localparam int ADDR_W        = (NUM_RESOURCES > 1) ? $clog2(NUM_RESOURCES) : 1;
    localparam int IDX_W         = 8;
    localparam int CODE_W        = 2;

    typedef enum logic [1:0] {
        OP_RECORD = 2'd0,
        OP_MASK   = 2'd1,
        OP_UNMASK = 2'd2,
        OP_CHECK  = 2'd3
    } op_t;

    typedef enum logic [CODE_W-1:0] {
        USE_UNUSED = 2'd0,
        USE_USED   = 2'd1,
        USE_CLASH  = 2'd2,
        USE_MASKED = 2'd3
    } usage_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_BAD   = 2'd1,
        ST_CLASH = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_MODIFY = 3'b010,
        S_SCAN   = 3'b100
    } state_t;

    typedef struct packed {
        op_t              op;
        logic [IDX_W-1:0] resource_index;
    } req_t;

    typedef struct packed {
        status_t          status;
        logic [IDX_W-1:0] error_index;
    } rsp_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        usage_t            data;
    } ram_wr_t;

endpackage

FILE: design/resource_usage_tracker.sv
// ----------------------------------------------------------------------------
// Resource usage tracker
// Keeps a two-bit usage code per resource and reports clashes.
// ----------------------------------------------------------------------------
// Record, mask and unmask are a read-modify-write: the entry is read from
// the table memory when the request is taken, then updated and the result
// loaded in the modify state. An index that is out of range is answered
// without a table read. A check scans the table one entry per cycle
// through the memory read port, stopping at the lowest entry in clash.
// The result sits in an output register, so the next request beat can be
// taken in the cycle the result beat is taken.
module resource_usage_tracker
    import utr_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp
);

    logic              out_free;
    logic [ADDR_W-1:0] ram_raddr;
    logic [CODE_W-1:0] ram_rdata;
    ram_wr_t           ram_wr;
    logic              rsp_load;
    rsp_t              rsp_data;
    logic              rsp_valid_reg, rsp_valid_next;
    rsp_t              rsp_reg;

    assign out_free = !rsp_valid_reg || !rsp_stall;

    utr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req       (req),
        .req_stall (req_stall),
        .out_free  (out_free),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata),
        .ram_wr    (ram_wr),
        .rsp_load  (rsp_load),
        .rsp_data  (rsp_data)
    );

    utr_ram #(
        .WIDTH (CODE_W),
        .DEPTH (NUM_RESOURCES)
    ) u_ram (
        .clk   (clk),
        .we    (ram_wr.en),
        .waddr (ram_wr.addr),
        .wdata (ram_wr.data),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        if (rsp_load)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (out_free)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rsp_load)
        begin
            rsp_reg <= rsp_data;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

FILE: design/utr_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port with registered read data.
// ----------------------------------------------------------------------------
module utr_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 64
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: design/utr_ctrl.sv
// ----------------------------------------------------------------------------
// Resource usage tracker sequencer
// Decodes each request, runs the read-modify-write of one entry or the
// clash scan, and keeps a valid bit for every entry of the table.
// ----------------------------------------------------------------------------
module utr_ctrl
    import utr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    input  req_t              req,
    output logic              req_stall,
    input  logic              out_free,
    output logic [ADDR_W-1:0] ram_raddr,
    input  logic [CODE_W-1:0] ram_rdata,
    output ram_wr_t           ram_wr,
    output logic              rsp_load,
    output rsp_t              rsp_data
);

    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(NUM_RESOURCES - 1);

    state_t                   state_reg, state_next;
    op_t                      op_reg, op_next;
    logic [ADDR_W-1:0]        idx_reg, idx_next;
    logic [ADDR_W-1:0]        scan_reg, scan_next;
    logic                     rd_valid_reg, rd_valid_next;
    logic [NUM_RESOURCES-1:0] valid_reg, valid_next;
    logic                     accept;
    logic                     in_range;
    usage_t                   entry;

    assign accept    = (state_reg == S_IDLE) && req_valid && out_free;
    assign req_stall = !((state_reg == S_IDLE) && out_free);
    assign in_range  = {1'b0, req.resource_index} < (IDX_W + 1)'(NUM_RESOURCES);
    assign entry     = rd_valid_reg ? usage_t'(ram_rdata) : USE_UNUSED;

    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        idx_next   = idx_reg;
        scan_next  = scan_reg;
        ram_raddr  = scan_reg + ADDR_W'(1);
        ram_wr     = '{en: 1'b0, addr: idx_reg, data: USE_USED};
        rsp_load   = 1'b0;
        rsp_data   = '{status: ST_OK, error_index: '0};

        case (state_reg)
            S_IDLE:
            begin
                ram_raddr = req.resource_index[ADDR_W-1:0];
                if (accept)
                begin
                    op_next  = req.op;
                    idx_next = req.resource_index[ADDR_W-1:0];
                    if (req.op == OP_CHECK)
                    begin
                        ram_raddr  = '0;
                        scan_next  = '0;
                        state_next = S_SCAN;
                    end
                    else if (!in_range)
                    begin
                        rsp_load = 1'b1;
                        rsp_data = '{status: ST_BAD, error_index: req.resource_index};
                    end
                    else
                    begin
                        state_next = S_MODIFY;
                    end
                end
            end
            S_MODIFY:
            begin
                rsp_load   = 1'b1;
                state_next = S_IDLE;
                case (op_reg)
                    OP_RECORD:
                    begin
                        if (entry == USE_USED)
                        begin
                            ram_wr   = '{en: 1'b1, addr: idx_reg, data: USE_CLASH};
                            rsp_data = '{status: ST_CLASH, error_index: IDX_W'(idx_reg)};
                        end
                        else if (entry != USE_MASKED)
                        begin
                            ram_wr = '{en: 1'b1, addr: idx_reg, data: USE_USED};
                        end
                    end
                    OP_MASK:
                    begin
                        if (entry != USE_USED)
                        begin
                            rsp_data = '{status: ST_CLASH, error_index: IDX_W'(idx_reg)};
                        end
                        else
                        begin
                            ram_wr = '{en: 1'b1, addr: idx_reg, data: USE_MASKED};
                        end
                    end
                    default:
                    begin
                        ram_wr = '{en: 1'b1, addr: idx_reg, data: USE_USED};
                    end
                endcase
            end
            S_SCAN:
            begin
                if (entry == USE_CLASH)
                begin
                    rsp_load   = 1'b1;
                    rsp_data   = '{status: ST_CLASH, error_index: IDX_W'(scan_reg)};
                    state_next = S_IDLE;
                end
                else if (scan_reg == LAST_ADDR)
                begin
                    rsp_load   = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    scan_next = scan_reg + ADDR_W'(1);
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (ram_wr.en)
        begin
            valid_next[ram_wr.addr] = 1'b1;
        end
        rd_valid_next = valid_reg[ram_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            op_reg       <= OP_RECORD;
            idx_reg      <= '0;
            scan_reg     <= '0;
            rd_valid_reg <= 1'b0;
            valid_reg    <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            op_reg       <= op_next;
            idx_reg      <= idx_next;
            scan_reg     <= scan_next;
            rd_valid_reg <= rd_valid_next;
            valid_reg    <= valid_next;
        end
    end

endmodule

FILE: tb/resource_usage_tracker_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Resource usage tracker testbench
// Drives record, mask, unmask and check requests into the tracker and
// compares every response beat with a behavioural copy of the usage table.
// The test runs directed corner cases, random traffic, a long output stall
// and a drain pause.
// ----------------------------------------------------------------------------
module resource_usage_tracker_test;
    import utr_pkg::*;

    logic   clk;
    logic   rst_n;
    logic   req_valid;
    logic   req_stall;
    req_t   req;
    logic   rsp_valid;
    logic   rsp_stall;
    rsp_t   rsp;

    usage_t usage_model [NUM_RESOURCES];
    rsp_t   pending_results [$];
    int     mismatch_count = 0;
    bit     send_gaps      = 1'b0;
    bit     recv_stalls    = 1'b0;
    int     hold_cycles    = 0;

    resource_usage_tracker dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic rsp_t track_usage(input req_t item);
        rsp_t              res;
        usage_t            cur;
        int                i;
        logic [ADDR_W-1:0] slot;
        res.status      = ST_OK;
        res.error_index = '0;
        if (item.op == OP_CHECK)
        begin
            for (i = NUM_RESOURCES - 1; i >= 0; i--)
            begin
                if (usage_model[i] == USE_CLASH)
                begin
                    res.status      = ST_CLASH;
                    res.error_index = IDX_W'(i);
                end
            end
            return res;
        end
        if (int'(item.resource_index) >= NUM_RESOURCES)
        begin
            res.status      = ST_BAD;
            res.error_index = item.resource_index;
            return res;
        end
        slot = item.resource_index[ADDR_W-1:0];
        cur  = usage_model[slot];
        case (item.op)
            OP_RECORD:
            begin
                if (cur == USE_USED)
                begin
                    usage_model[slot] = USE_CLASH;
                    res.status      = ST_CLASH;
                    res.error_index = item.resource_index;
                end
                else if (cur != USE_MASKED)
                begin
                    usage_model[slot] = USE_USED;
                end
            end
            OP_MASK:
            begin
                if (cur == USE_USED)
                begin
                    usage_model[slot] = USE_MASKED;
                end
                else
                begin
                    res.status      = ST_CLASH;
                    res.error_index = item.resource_index;
                end
            end
            default:
            begin
                usage_model[slot] = USE_USED;
            end
        endcase
        return res;
    endfunction

    // Each beat is offered at a rising edge and held until the tracker takes it.
    task automatic issue_op(input op_t op, input int idx);
        req_t item;
        item.op             = op;
        item.resource_index = IDX_W'(idx);
        while (send_gaps && $urandom_range(99) < 30)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= item;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        pending_results.push_back(track_usage(item));
    endtask

    task automatic close_burst();
        req_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        rsp_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_cycles > 0)
            begin
                rsp_stall   <= 1'b1;
                hold_cycles = hold_cycles - 1;
            end
            else if (recv_stalls)
                rsp_stall <= ($urandom_range(99) < 30);
            else
                rsp_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $error("response beat with nothing expected: status %0d error_index %0d",
                       rsp.status, rsp.error_index);
                mismatch_count++;
            end
            else
            begin
                if (rsp.status !== pending_results[0].status)
                begin
                    $error("status: expected %0d, got %0d",
                           pending_results[0].status, rsp.status);
                    mismatch_count++;
                end
                if (rsp.error_index !== pending_results[0].error_index)
                begin
                    $error("error_index: expected %0d, got %0d",
                           pending_results[0].error_index, rsp.error_index);
                    mismatch_count++;
                end
                void'(pending_results.pop_front());
            end
        end
    end

    task automatic test_directed_cases();
        send_gaps   = 1'b0;
        recv_stalls = 1'b0;
        issue_op(OP_CHECK, 0);
        issue_op(OP_RECORD, 0);
        issue_op(OP_RECORD, 0);
        issue_op(OP_CHECK, 0);
        issue_op(OP_RECORD, 0);
        issue_op(OP_MASK, 0);
        issue_op(OP_RECORD, 0);
        issue_op(OP_MASK, 0);
        issue_op(OP_UNMASK, 0);
        issue_op(OP_MASK, NUM_RESOURCES - 1);
        issue_op(OP_RECORD, NUM_RESOURCES - 1);
        issue_op(OP_RECORD, NUM_RESOURCES - 1);
        issue_op(OP_CHECK, 255);
        issue_op(OP_RECORD, NUM_RESOURCES);
        issue_op(OP_MASK, 128);
        issue_op(OP_UNMASK, 255);
        issue_op(OP_UNMASK, 5);
        issue_op(OP_RECORD, 5);
        issue_op(OP_CHECK, 0);
        issue_op(OP_UNMASK, 5);
        issue_op(OP_UNMASK, NUM_RESOURCES - 1);
        issue_op(OP_CHECK, 170);
        close_burst();
    endtask

    task automatic test_random_traffic(input int count);
        int   n;
        int   pick;
        int   idx;
        op_t  op;
        for (n = 0; n < count; n++)
        begin
            send_gaps   = (n >= 80);
            recv_stalls = (n >= 80);
            pick = $urandom_range(99);
            if (pick < 40)
                op = OP_RECORD;
            else if (pick < 60)
                op = OP_MASK;
            else if (pick < 90)
                op = OP_UNMASK;
            else
                op = OP_CHECK;
            pick = $urandom_range(99);
            if (pick < 45)
                idx = $urandom_range(7);
            else if (pick < 85)
                idx = $urandom_range(NUM_RESOURCES - 1);
            else
                idx = $urandom_range(255, NUM_RESOURCES);
            issue_op(op, idx);
        end
        close_burst();
    endtask

    // The receiver holds off long enough for the tracker to stall its input.
    task automatic test_output_backpressure();
        int n;
        send_gaps   = 1'b0;
        recv_stalls = 1'b0;
        hold_cycles = 150;
        for (n = 0; n < 20; n++)
            issue_op(op_t'($urandom_range(2)), $urandom_range(15));
        close_burst();
    endtask

    task automatic test_pause_and_resume();
        int n;
        send_gaps   = 1'b1;
        recv_stalls = 1'b1;
        for (n = 0; n < 16; n++)
        begin
            issue_op(op_t'($urandom_range(3)), $urandom_range(NUM_RESOURCES - 1));
            if (n == 7)
                close_burst();
        end
        close_burst();
    endtask

    initial
    begin
        rst_n     <= 1'b0;
        req_valid <= 1'b0;
        req       <= '0;
        foreach (usage_model[i])
            usage_model[i] = USE_UNUSED;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_cases();
        test_random_traffic(395);
        test_output_backpressure();
        test_pause_and_resume();

        repeat (NUM_RESOURCES + 4) @(posedge clk);
        if (pending_results.size() != 0)
        begin
            $error("%0d response beats never arrived", pending_results.size());
            mismatch_count++;
        end
        if (mismatch_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
